>>> hw/rtl/sss_pkg.sv
package sss_pkg;

  // Set size and sample format.
  localparam int MAX_SAMPLES = 16;
  localparam int SAMPLE_BITS = 16;

  // Derived widths.
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = $clog2(MAX_SAMPLES);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS;
  localparam int ACC_W  = SQ_W + CNT_W;
  localparam int DIV_W  = ACC_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int VAR_W  = 33;

  // Stream data widths, padded to whole bytes.
  localparam int IN_RAW_W  = SAMPLE_BITS;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 4 * SAMPLE_BITS + 2 * CNT_W + VAR_W + 1;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // store and account for the incoming sample
    logic mean_start;    // start dividing the sum by the count
    logic mean_capture;  // take the quotient as the mean
    logic sq_clear;      // clear the accumulator, the read index and the variance
    logic sq_read;       // read the store at the current index
    logic sq_diff;       // form the magnitude of the deviation
    logic sq_mul;        // square the deviation
    logic sq_acc;        // accumulate the square and advance the index
    logic var_start;     // start dividing the squares by count minus one
    logic var_capture;   // take the quotient as the variance
    logic result_load;   // load the output register
    logic clear_set;     // clear the running state for the next set
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_full;
    logic count_gt1;
    logic idx_last;
    logic div_busy;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

>>> hw/rtl/sss_divider.sv
module sss_divider
  import sss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dsr;
  logic [DIV_W-1:0]  quo;
  logic [DCNT_W-1:0] steps;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = (trial >= {1'b0, dsr});
  end

  // Control: step counter and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DCNT_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Payload: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient = quo;

  // A completion strobe only ever follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider finished without running");

endmodule

>>> hw/rtl/sss_datapath.sv
module sss_datapath
  import sss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  logic signed [SAMPLE_BITS-1:0] store [MAX_SAMPLES];
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic [CNT_W-1:0]              count;
  logic signed [SAMPLE_BITS-1:0] high;
  logic signed [SAMPLE_BITS-1:0] low;
  logic signed [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]              pos_tally;
  logic [CNT_W-1:0]              neg_tally;
  logic [IDX_W-1:0]              idx;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS-1:0]        dev_mag;
  logic [SQ_W-1:0]               sq;
  logic [ACC_W-1:0]              acc;
  logic [VAR_W-1:0]              variance;
  logic signed [SAMPLE_BITS:0]   dev;
  logic [SUM_W-1:0]              sum_mag;
  logic [SAMPLE_BITS-1:0]        mean_mag;
  logic                          div_start;
  logic [DIV_W-1:0]              div_dividend;
  logic [CNT_W-1:0]              div_divisor;
  logic                          div_busy;
  logic                          div_done;
  logic [DIV_W-1:0]              div_quotient;
  logic                          out_free;
  logic [SAMPLE_BITS-1:0]        spread;

  assign sample = s_tdata[SAMPLE_BITS-1:0];

  // Sample store: written while loading, read once per entry in the second pass.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      store[count[IDX_W-1:0]] <= sample;
    end
    if (cmd.sq_read) begin
      rd_data <= store[idx];
    end
  end

  // Running count, extremes, sum and sign tallies.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_set) begin
      count     <= '0;
      high      <= '0;
      low       <= '0;
      sum       <= '0;
      pos_tally <= '0;
      neg_tally <= '0;
    end else if (cmd.load) begin
      count <= count + 1'b1;
      sum   <= sum + SUM_W'(sample);
      if (count == '0) begin
        high <= sample;
        low  <= sample;
      end else begin
        if (sample > high) high <= sample;
        if (sample < low)  low  <= sample;
      end
      if (sample > 0) pos_tally <= pos_tally + 1'b1;
      if (sample < 0) neg_tally <= neg_tally + 1'b1;
    end
  end

  // Shared divider: sum magnitude over count, then squares over count minus one.
  assign sum_mag      = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign div_start    = cmd.mean_start | cmd.var_start;
  assign div_dividend = cmd.var_start ? acc : DIV_W'(sum_mag);
  assign div_divisor  = cmd.var_start ? count - 1'b1 : count;
  assign mean_mag     = div_quotient[SAMPLE_BITS-1:0];

  sss_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Deviation of the stored sample from the integer mean.
  assign dev = {rd_data[SAMPLE_BITS-1], rd_data} - {mean[SAMPLE_BITS-1], mean};

  // Second pass: mean, deviation, square and accumulation registers.
  always_ff @(posedge clk) begin
    if (cmd.mean_capture) begin
      mean <= sum[SUM_W-1] ? -mean_mag : mean_mag;
    end
    if (cmd.sq_diff) begin
      dev_mag <= dev[SAMPLE_BITS] ? SAMPLE_BITS'(-dev) : dev[SAMPLE_BITS-1:0];
    end
    if (cmd.sq_mul) begin
      sq <= dev_mag * dev_mag;
    end
    if (cmd.sq_clear) begin
      acc      <= '0;
      idx      <= '0;
      variance <= '0;
    end else begin
      if (cmd.sq_acc) begin
        acc <= acc + ACC_W'(sq);
        idx <= idx + 1'b1;
      end
      if (cmd.var_capture) begin
        variance <= div_quotient[VAR_W-1:0];
      end
    end
  end

  // Output register: holds one result until the receiver takes it.
  assign out_free = !m_tvalid || m_tready;
  assign spread   = high - low;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      m_tdata <= OUT_W'({(count > CNT_W'(1)), variance, mean, neg_tally, pos_tally,
                         spread, low, high});
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.count_full = (count == CNT_W'(MAX_SAMPLES));
    stat.count_gt1  = (count > CNT_W'(1));
    stat.idx_last   = (CNT_W'(idx) == count - 1'b1);
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.out_free   = out_free;
  end

  // The count never runs past the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond store depth");

  // A result is only loaded when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> out_free)
    else $error("result overwrote an untaken transfer");

endmodule

>>> hw/rtl/sss_controller.sv
module sss_controller
  import sss_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  input  logic  s_tlast,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_MEAN_DIV  = 4'd1;
  localparam logic [3:0] S_MEAN_WAIT = 4'd2;
  localparam logic [3:0] S_READ      = 4'd3;
  localparam logic [3:0] S_DIFF      = 4'd4;
  localparam logic [3:0] S_MUL       = 4'd5;
  localparam logic [3:0] S_ACC       = 4'd6;
  localparam logic [3:0] S_VAR_DIV   = 4'd7;
  localparam logic [3:0] S_VAR_WAIT  = 4'd8;
  localparam logic [3:0] S_OUT       = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign s_tready = (state == S_LOAD);
  assign accept   = s_tvalid && s_tready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          cmd.load = !stat.count_full;
          if (s_tlast) state_next = S_MEAN_DIV;
        end
      end
      S_MEAN_DIV: begin
        cmd.mean_start = 1'b1;
        state_next     = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (stat.div_done) begin
          cmd.mean_capture = 1'b1;
          cmd.sq_clear     = 1'b1;
          state_next       = S_READ;
        end
      end
      S_READ: begin
        cmd.sq_read = 1'b1;
        state_next  = S_DIFF;
      end
      S_DIFF: begin
        cmd.sq_diff = 1'b1;
        state_next  = S_MUL;
      end
      S_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.sq_acc = 1'b1;
        if (!stat.idx_last)      state_next = S_READ;
        else if (stat.count_gt1) state_next = S_VAR_DIV;
        else                     state_next = S_OUT;
      end
      S_VAR_DIV: begin
        cmd.var_start = 1'b1;
        state_next    = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (stat.div_done) begin
          cmd.var_capture = 1'b1;
          state_next      = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.result_load = 1'b1;
          cmd.clear_set   = 1'b1;
          state_next      = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // A closing sample always leads straight into the mean division.
  a_last_to_div: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (state == S_MEAN_DIV))
    else $error("closing sample did not start the mean division");

  // The divider is never restarted while it is still running.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.mean_start || cmd.var_start) |-> !stat.div_busy)
    else $error("divider started while busy");

  // In the second pass the last index, a count of one and a full count never hold together.
  a_pass_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !(stat.idx_last && !stat.count_gt1 && stat.count_full))
    else $error("second pass over an inconsistent count");

endmodule

>>> hw/rtl/sample_set_statistics.sv
// Sample set statistics.
//
// Samples arrive on the slave stream, one signed sample per transfer in
// s_tdata, with s_tlast on the final sample of a set. Up to MAX_SAMPLES
// samples are stored; further samples of the same set are dropped, but their
// s_tlast still closes the set. Each closed set produces one transfer on the
// master stream with the extremes, spread, sign counts, truncated mean and
// sample variance (variance_valid low for a single-sample set).
//
// Throughput: samples load at one per cycle while the block is loading. After
// the closing sample of a set the block stops accepting while it runs the mean
// division, the second pass (read, deviation, square and accumulate for each
// stored sample), the variance division (skipped for a single-sample set) and
// the load of the output register; m_tvalid rises once that load is done.
//
// Reset clears the controller, the running state and the output valid flag.
// When the receiver stalls, the finished result waits in the output register
// and the next set loads meanwhile; it waits for the register to empty only
// when its own result is ready.
module sample_set_statistics
  import sss_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // sample
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // highest, lowest, spread, positive_count,
                                      // negative_count, mean, variance,
                                      // variance_valid, zero padding
);

  cmd_t  cmd;
  stat_t stat;

  sss_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
